### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with reset disable, for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/lspf_pkg.sv
// ----------------------------------------------------------------------------
// Shadow point filter package
// Fixed widths, register codes, reset values and control and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lspf_pkg;

    localparam int CFG_WIDTH      = 17;
    localparam int RATIO_WIDTH    = 20;
    localparam int Q16            = 16;
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [CFG_WIDTH-1:0] INVALID_MM = 17'd100000;
    localparam logic [CFG_WIDTH-1:0] COS_ONE    = 17'd65536;

    localparam logic [1:0] REG_MAX_DISTANCE     = 2'd0;
    localparam logic [1:0] REG_MIN_THRESH       = 2'd1;
    localparam logic [1:0] REG_COS_TWO_STEPS    = 2'd2;
    localparam logic [1:0] REG_BREAKPOINT_RATIO = 2'd3;

    localparam logic [CFG_WIDTH-1:0]   RST_MAX_DISTANCE     = 17'd3000;
    localparam logic [CFG_WIDTH-1:0]   RST_MIN_THRESH       = 17'd20;
    localparam logic [CFG_WIDTH-1:0]   RST_COS_TWO_STEPS    = 17'd65533;
    localparam logic [RATIO_WIDTH-1:0] RST_BREAKPOINT_RATIO = 20'd3380;

    typedef struct packed {
        logic shift;
        logic clear;
        logic mark_all;
    } win_ctrl_t;

    typedef struct packed {
        logic full;
        logic test_ok;
    } win_stat_t;

    typedef struct packed {
        logic done;
        logic beyond;
    } chord_stat_t;

endpackage

`default_nettype wire

### sv/lspf_window.sv
// ----------------------------------------------------------------------------
// Sample window
// Shift register of ranges and removal marks, fill count and centre pretest.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_window
    import lspf_pkg::*;
#(
    parameter int NEIGHBOUR_STEP = 2,
    parameter int RANGE_BITS     = 17,
    localparam int WIN    = 2 * NEIGHBOUR_STEP + 1,
    localparam int IDX_W  = $clog2(WIN),
    localparam int SEEN_W = $clog2(WIN + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire win_ctrl_t             ctrl,
    input  wire logic [RANGE_BITS-1:0] range_in,
    input  wire logic [CFG_WIDTH-1:0]  range_limit,
    input  wire logic [IDX_W-1:0]      rd_idx,
    output logic [RANGE_BITS-1:0]      centre,
    output logic [RANGE_BITS-1:0]      left,
    output logic [RANGE_BITS-1:0]      right,
    output logic [RANGE_BITS-1:0]      rd_range,
    output logic                       rd_mark,
    output logic [SEEN_W-1:0]          seen,
    output win_stat_t                  stat
);

    localparam int CW = (RANGE_BITS > CFG_WIDTH) ? RANGE_BITS : CFG_WIDTH;
    localparam logic [SEEN_W-1:0] WIN_SEEN = SEEN_W'(WIN);

    logic [RANGE_BITS-1:0] ranges_reg [WIN];
    logic [RANGE_BITS-1:0] ranges_next [WIN];
    logic [WIN-1:0]        marks_reg;
    logic [WIN-1:0]        marks_next;
    logic [SEEN_W-1:0]     seen_reg;
    logic [SEEN_W-1:0]     seen_next;

    logic rising;
    logic falling;
    logic steps_ok;
    logic centre_ok;

    always_comb
    begin
        ranges_next = ranges_reg;
        marks_next  = marks_reg;
        seen_next   = seen_reg;
        if (ctrl.clear)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                ranges_next[k] = '0;
            end
            marks_next = '0;
            seen_next  = '0;
        end
        else if (ctrl.shift)
        begin
            for (int k = 0; k < WIN - 1; k++)
            begin
                ranges_next[k] = ranges_reg[k + 1];
                marks_next[k]  = marks_reg[k + 1];
            end
            ranges_next[WIN-1] = range_in;
            marks_next[WIN-1]  = 1'b0;
            if (seen_reg != WIN_SEEN)
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
        else if (ctrl.mark_all)
        begin
            marks_next = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                ranges_reg[k] <= '0;
            end
            marks_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            ranges_reg <= ranges_next;
            marks_reg  <= marks_next;
            seen_reg   <= seen_next;
        end
    end

    assign centre = ranges_reg[NEIGHBOUR_STEP];
    assign left   = ranges_reg[0];
    assign right  = ranges_reg[2 * NEIGHBOUR_STEP];

    assign rising  = right > left;
    assign falling = right < left;

    always_comb
    begin
        steps_ok = 1'b1;
        for (int k = 0; k < 2 * NEIGHBOUR_STEP; k++)
        begin
            if (rising)
            begin
                steps_ok = steps_ok & (ranges_reg[k + 1] > ranges_reg[k]);
            end
            else
            begin
                steps_ok = steps_ok & (ranges_reg[k + 1] < ranges_reg[k]);
            end
        end
    end

    assign centre_ok = (CW'(centre) != CW'(INVALID_MM)) && (centre != '0)
                    && (CW'(centre) <= CW'(range_limit));

    assign stat.full    = seen_reg == WIN_SEEN;
    assign stat.test_ok = centre_ok && (rising || falling) && steps_ok;

    assign rd_range = ranges_reg[rd_idx];
    assign rd_mark  = marks_reg[rd_idx];
    assign seen     = seen_reg;

endmodule

`default_nettype wire

### sv/lspf_chord.sv
// ----------------------------------------------------------------------------
// Chord test unit
// One shared multiplier and accumulator, sequenced over eight products, that
// decide whether a chord squared exceeds the squared range threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_chord
    import lspf_pkg::*;
#(
    parameter int RANGE_BITS = 17
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [RANGE_BITS-1:0]  x_in,
    input  wire logic [RANGE_BITS-1:0]  y_in,
    input  wire logic [RANGE_BITS-1:0]  base_in,
    input  wire logic [CFG_WIDTH-1:0]   cos_q16,
    input  wire logic [RATIO_WIDTH-1:0] ratio,
    input  wire logic [CFG_WIDTH-1:0]   thresh_floor,
    output chord_stat_t                 stat
);

    localparam int RB    = RANGE_BITS;
    localparam int MINW  = CFG_WIDTH + Q16;
    localparam int TW    = ((RB + RATIO_WIDTH > MINW) ? RB + RATIO_WIDTH : MINW) + 1;
    localparam int THW   = TW - RB;
    localparam int MW    = (RB > THW) ? RB : THW;
    localparam int PW    = 2 * MW;
    localparam int AW    = ((2 * RB + 34 > 2 * TW) ? 2 * RB + 34 : 2 * TW) + 2;

    localparam int SH_DD  = 2 * Q16;
    localparam int SH_XL  = Q16 + 1;
    localparam int SH_XH  = Q16 + 1 + RB;
    localparam int SH_THL = RB + 1;
    localparam int SH_THH = 2 * RB;

    localparam logic [3:0] SEQ_IDLE  = 4'd0;
    localparam logic [3:0] SEQ_XY    = 4'd1;
    localparam logic [3:0] SEQ_BT    = 4'd2;
    localparam logic [3:0] SEQ_DD    = 4'd3;
    localparam logic [3:0] SEQ_XL    = 4'd4;
    localparam logic [3:0] SEQ_XH    = 4'd5;
    localparam logic [3:0] SEQ_TLL   = 4'd6;
    localparam logic [3:0] SEQ_THL   = 4'd7;
    localparam logic [3:0] SEQ_THH   = 4'd8;
    localparam logic [3:0] SEQ_DRAIN = 4'd9;
    localparam logic [3:0] SEQ_DONE  = 4'd10;

    logic [3:0] seq_reg;
    logic [3:0] seq_next;
    logic [3:0] op_reg;
    logic [3:0] op_next;

    logic [RB-1:0]   x_reg;
    logic [RB-1:0]   y_reg;
    logic [RB-1:0]   base_reg;
    logic [RB-1:0]   d_reg;
    logic [2*RB-1:0] xy_reg;
    logic [2*RB-1:0] xy_next;
    logic [TW-1:0]   t_reg;
    logic [TW-1:0]   t_next;
    logic [PW-1:0]   prod_reg;
    logic [PW-1:0]   prod_next;
    logic [AW-1:0]   acc_reg;
    logic [AW-1:0]   acc_next;

    logic [CFG_WIDTH-1:0] cosq;
    logic [CFG_WIDTH-1:0] k_q16;
    logic [MW-1:0]        opa;
    logic [MW-1:0]        opb;
    logic [RB-1:0]        t_lo;
    logic [THW-1:0]       t_hi;
    logic                 load;

    assign cosq  = (cos_q16 > COS_ONE) ? COS_ONE : cos_q16;
    assign k_q16 = COS_ONE - cosq;
    assign t_lo  = t_reg[RB-1:0];
    assign t_hi  = t_reg[TW-1:RB];
    assign load  = start && (seq_reg == SEQ_IDLE);

    always_comb
    begin
        seq_next = SEQ_IDLE;
        op_next  = seq_reg;
        opa      = '0;
        opb      = '0;
        case (seq_reg)
            SEQ_IDLE:
            begin
                seq_next = load ? SEQ_XY : SEQ_IDLE;
                op_next  = SEQ_IDLE;
            end
            SEQ_XY:
            begin
                seq_next = SEQ_BT;
                opa      = MW'(x_reg);
                opb      = MW'(y_reg);
            end
            SEQ_BT:
            begin
                seq_next = SEQ_DD;
                opa      = MW'(base_reg);
                opb      = MW'(ratio);
            end
            SEQ_DD:
            begin
                seq_next = SEQ_XL;
                opa      = MW'(d_reg);
                opb      = MW'(d_reg);
            end
            SEQ_XL:
            begin
                seq_next = SEQ_XH;
                opa      = MW'(xy_reg[RB-1:0]);
                opb      = MW'(k_q16);
            end
            SEQ_XH:
            begin
                seq_next = SEQ_TLL;
                opa      = MW'(xy_reg[2*RB-1:RB]);
                opb      = MW'(k_q16);
            end
            SEQ_TLL:
            begin
                seq_next = SEQ_THL;
                opa      = MW'(t_lo);
                opb      = MW'(t_lo);
            end
            SEQ_THL:
            begin
                seq_next = SEQ_THH;
                opa      = MW'(t_hi);
                opb      = MW'(t_lo);
            end
            SEQ_THH:
            begin
                seq_next = SEQ_DRAIN;
                opa      = MW'(t_hi);
                opb      = MW'(t_hi);
            end
            SEQ_DRAIN:
            begin
                seq_next = SEQ_DONE;
                op_next  = SEQ_IDLE;
            end
            SEQ_DONE:
            begin
                seq_next = SEQ_IDLE;
                op_next  = SEQ_IDLE;
            end
            default:
            begin
                seq_next = SEQ_IDLE;
                op_next  = SEQ_IDLE;
            end
        endcase
    end

    assign prod_next = PW'(opa) * PW'(opb);

    always_comb
    begin
        xy_next  = xy_reg;
        t_next   = t_reg;
        acc_next = acc_reg;
        case (op_reg)
            SEQ_XY:  xy_next  = prod_reg[2*RB-1:0];
            SEQ_BT:  t_next   = TW'(prod_reg) + TW'({thresh_floor, {Q16{1'b0}}});
            SEQ_DD:  acc_next = AW'(prod_reg) << SH_DD;
            SEQ_XL:  acc_next = acc_reg + (AW'(prod_reg) << SH_XL);
            SEQ_XH:  acc_next = acc_reg + (AW'(prod_reg) << SH_XH);
            SEQ_TLL: acc_next = acc_reg - AW'(prod_reg);
            SEQ_THL: acc_next = acc_reg - (AW'(prod_reg) << SH_THL);
            SEQ_THH: acc_next = acc_reg - (AW'(prod_reg) << SH_THH);
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_IDLE;
            op_reg  <= SEQ_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
            op_reg  <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            base_reg <= base_in;
            d_reg    <= (x_in > y_in) ? x_in - y_in : y_in - x_in;
        end
        prod_reg <= prod_next;
        xy_reg   <= xy_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
    end

    assign stat.done   = seq_reg == SEQ_DONE;
    assign stat.beyond = !acc_reg[AW-1] && (acc_reg != '0);

endmodule

`default_nettype wire

### sv/lidar_shadow_point_filter.sv
// ----------------------------------------------------------------------------
// Lidar shadow point filter: one sample at a time; each accepted sample is checked
// against the window, then up to two chord tests run on the shared multiplier,
// then the output words are prepared and sent (none while filling, one per sample,
// up to five at scan end), each held while result_stall is high. Reset loads
// register defaults and empties the window.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_shadow_point_filter
    import lspf_pkg::*;
#(
    parameter int NEIGHBOUR_STEP = 2,
    parameter int RANGE_BITS     = 17
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0]      prdata,
    output logic                           pready,
    input  wire logic                      sample_valid,
    output logic                           sample_stall,
    input  wire logic [RANGE_BITS-1:0]     range_mm,
    input  wire logic                      scan_end,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic [RANGE_BITS-1:0]          range_out_mm,
    output logic                           removed,
    output logic                           scan_last
);

    localparam int WIN    = 2 * NEIGHBOUR_STEP + 1;
    localparam int IDX_W  = $clog2(WIN);
    localparam int SEEN_W = $clog2(WIN + 1);
    localparam logic [SEEN_W-1:0] WIN_SEEN = SEEN_W'(WIN);
    localparam logic [IDX_W-1:0]  IDX_TOP  = IDX_W'(WIN - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_TEST_A = 3'd2;
    localparam logic [2:0] ST_WAIT_A = 3'd3;
    localparam logic [2:0] ST_TEST_B = 3'd4;
    localparam logic [2:0] ST_WAIT_B = 3'd5;
    localparam logic [2:0] ST_PREP   = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [CFG_WIDTH-1:0]   range_limit_reg;
    logic [CFG_WIDTH-1:0]   thresh_floor_reg;
    logic [CFG_WIDTH-1:0]   cos_two_steps_reg;
    logic [RATIO_WIDTH-1:0] breakpoint_ratio_reg;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic             end_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [RANGE_BITS-1:0] range_out_reg;
    logic             removed_reg;
    logic             scan_last_reg;

    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic             accept;
    logic             out_free;
    logic             emit_load;
    logic [IDX_W-1:0] last_idx;

    win_ctrl_t             win_ctrl;
    win_stat_t             win_stat;
    chord_stat_t           chord_stat;
    logic [RANGE_BITS-1:0] centre;
    logic [RANGE_BITS-1:0] left;
    logic [RANGE_BITS-1:0] right;
    logic [RANGE_BITS-1:0] rd_range;
    logic                  rd_mark;
    logic [SEEN_W-1:0]     seen;
    logic                  chord_start;
    logic [RANGE_BITS-1:0] chord_y;
    logic [RANGE_BITS-1:0] chord_base;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg      <= RST_MAX_DISTANCE;
            thresh_floor_reg     <= RST_MIN_THRESH;
            cos_two_steps_reg    <= RST_COS_TWO_STEPS;
            breakpoint_ratio_reg <= RST_BREAKPOINT_RATIO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_DISTANCE:     range_limit_reg      <= pwdata[CFG_WIDTH-1:0];
                REG_MIN_THRESH:       thresh_floor_reg     <= pwdata[CFG_WIDTH-1:0];
                REG_COS_TWO_STEPS:    cos_two_steps_reg    <= pwdata[CFG_WIDTH-1:0];
                REG_BREAKPOINT_RATIO: breakpoint_ratio_reg <= pwdata[RATIO_WIDTH-1:0];
                default:              range_limit_reg      <= range_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_MAX_DISTANCE:     prdata = APB_DATA_WIDTH'(range_limit_reg);
            REG_MIN_THRESH:       prdata = APB_DATA_WIDTH'(thresh_floor_reg);
            REG_COS_TWO_STEPS:    prdata = APB_DATA_WIDTH'(cos_two_steps_reg);
            REG_BREAKPOINT_RATIO: prdata = APB_DATA_WIDTH'(breakpoint_ratio_reg);
            default:              prdata = '0;
        endcase
    end

    assign sample_stall = state_reg != ST_IDLE;
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign emit_load    = (state_reg == ST_EMIT) && out_free;
    assign last_idx     = end_reg ? IDX_TOP : '0;

    assign chord_start = (state_reg == ST_TEST_A) || (state_reg == ST_TEST_B);
    assign chord_y     = (state_reg == ST_TEST_A) ? left : right;
    assign chord_base  = (state_reg == ST_TEST_A) ? centre : right;

    assign win_ctrl.shift    = accept;
    assign win_ctrl.mark_all = (state_reg == ST_WAIT_B) && chord_stat.done && chord_stat.beyond;
    assign win_ctrl.clear    = emit_load && (idx_reg == last_idx) && end_reg;

    lspf_window #(
        .NEIGHBOUR_STEP (NEIGHBOUR_STEP),
        .RANGE_BITS     (RANGE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (win_ctrl),
        .range_in     (range_mm),
        .range_limit  (range_limit_reg),
        .rd_idx       (idx_reg),
        .centre       (centre),
        .left         (left),
        .right        (right),
        .rd_range     (rd_range),
        .rd_mark      (rd_mark),
        .seen         (seen),
        .stat         (win_stat)
    );

    lspf_chord #(
        .RANGE_BITS (RANGE_BITS)
    ) u_chord (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (chord_start),
        .x_in         (centre),
        .y_in         (chord_y),
        .base_in      (chord_base),
        .cos_q16      (cos_two_steps_reg),
        .ratio        (breakpoint_ratio_reg),
        .thresh_floor (thresh_floor_reg),
        .stat         (chord_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (win_stat.full && win_stat.test_ok) ? ST_TEST_A : ST_PREP;
            end
            ST_TEST_A:
            begin
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (chord_stat.done)
                begin
                    state_next = chord_stat.beyond ? ST_TEST_B : ST_PREP;
                end
            end
            ST_TEST_B:
            begin
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B:
            begin
                if (chord_stat.done)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                idx_next   = end_reg ? IDX_W'(WIN_SEEN - seen) : '0;
                state_next = (end_reg || win_stat.full) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            end_reg <= scan_end;
        end
        if (emit_load)
        begin
            range_out_reg <= rd_mark ? RANGE_BITS'(INVALID_MM) : rd_range;
            removed_reg   <= rd_mark;
            scan_last_reg <= end_reg && (idx_reg == IDX_TOP);
        end
    end

    assign result_valid = out_valid_reg;
    assign range_out_mm = range_out_reg;
    assign removed      = removed_reg;
    assign scan_last    = scan_last_reg;

endmodule

`default_nettype wire

### sv/lspf_checker.sv
// ----------------------------------------------------------------------------
// Shadow point filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lspf_checker
    import lspf_pkg::*;
#(
    parameter int RANGE_BITS = 17
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  sample_valid,
    input wire logic                  sample_stall,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire logic [RANGE_BITS-1:0] range_out_mm,
    input wire logic                  removed,
    input wire logic                  scan_last
);

    // hold a stalled word
    `ASSERT_NEXT(a_hold_result, clk, rst_n, result_valid && result_stall, result_valid && $stable(range_out_mm) && $stable(removed) && $stable(scan_last))

    `ASSERT_SAME(a_removed_code, clk, rst_n, result_valid && removed, range_out_mm == RANGE_BITS'(INVALID_MM))

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall, sample_stall)

    `ASSERT_SAME(a_load_while_busy, clk, rst_n, $rose(result_valid), $past(sample_stall))

endmodule

bind lidar_shadow_point_filter lspf_checker #(
    .RANGE_BITS (RANGE_BITS)
) u_lspf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .range_out_mm (range_out_mm),
    .removed      (removed),
    .scan_last    (scan_last)
);

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// Shadow point filter testbench
// Streams lidar scans through the filter under several register settings and
// idle and stall patterns. A local model of the window predicts every output word,
// and a monitor compares each accepted word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
    import lspf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTEP = 2;
    localparam int RBITS = 17;
    localparam int WIN   = 2 * NSTEP + 1;
    localparam int RMAX  = (1 << RBITS) - 1;

    typedef struct {
        logic [RBITS-1:0] mm;
        logic             last;
    } sample_t;

    typedef struct {
        logic [RBITS-1:0] mm;
        logic             removed;
        logic             last;
    } out_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    logic [RBITS-1:0]          range_mm = '0;
    logic                      scan_end = 1'b0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic [RBITS-1:0]          range_out_mm;
    logic                      removed;
    logic                      scan_last;

    sample_t   pending_samples[$];
    out_word_t expected_words[$];
    out_word_t want;
    sample_t   next_sample;
    int        queued = 0;
    int        accepted = 0;
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    logic [CFG_WIDTH-1:0]   max_dist  = RST_MAX_DISTANCE;
    logic [CFG_WIDTH-1:0]   min_th    = RST_MIN_THRESH;
    logic [CFG_WIDTH-1:0]   cos_q16   = RST_COS_TWO_STEPS;
    logic [RATIO_WIDTH-1:0] ratio_q16 = RST_BREAKPOINT_RATIO;

    logic [RBITS-1:0] win_mm[WIN];
    logic             win_mark[WIN];
    int               win_fill = 0;

    lidar_shadow_point_filter #(
        .NEIGHBOUR_STEP(NSTEP),
        .RANGE_BITS    (RBITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .range_mm    (range_mm),
        .scan_end    (scan_end),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .range_out_mm(range_out_mm),
        .removed     (removed),
        .scan_last   (scan_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int k = 0; k < WIN; k++)
        begin
            win_mm[k] = '0;
            win_mark[k] = 1'b0;
        end
    end

    function automatic logic chord_exceeds(logic [127:0] x, logic [127:0] y,
                                           logic [127:0] base);
        logic [127:0] cosq;
        logic [127:0] ratio;
        logic [127:0] floor_mm;
        logic [127:0] d;
        logic [127:0] t;
        cosq = (cos_q16 > COS_ONE) ? COS_ONE : cos_q16;
        ratio = ratio_q16;
        floor_mm = min_th;
        d = ((x * x + y * y) << Q16) - 2 * x * y * cosq;
        d = d << Q16;
        t = base * ratio + (floor_mm << Q16);
        return d > t * t;
    endfunction

    task automatic predict_sample(logic [RBITS-1:0] mm, logic fin);
        int        trend;
        int        p;
        int        q;
        int        lo;
        int        hi;
        logic      tested;
        out_word_t w;
        for (int k = 0; k < WIN - 1; k++)
        begin
            win_mm[k] = win_mm[k + 1];
            win_mark[k] = win_mark[k + 1];
        end
        win_mm[WIN - 1] = mm;
        win_mark[WIN - 1] = 1'b0;
        if (win_fill < WIN)
            win_fill++;
        if (win_fill == WIN)
        begin
            p = win_mm[WIN - 1];
            q = win_mm[0];
            trend = p - q;
            tested = !(win_mm[NSTEP] == INVALID_MM || win_mm[NSTEP] == 0 ||
                       win_mm[NSTEP] > max_dist || trend == 0);
            for (int k = 0; k < WIN - 1; k++)
            begin
                p = win_mm[k + 1];
                q = win_mm[k];
                if (trend > 0 ? (p - q <= 0) : (p - q >= 0))
                    tested = 1'b0;
            end
            if (tested && chord_exceeds(win_mm[NSTEP], win_mm[0], win_mm[NSTEP]) &&
                chord_exceeds(win_mm[NSTEP], win_mm[WIN - 1], win_mm[WIN - 1]))
                for (int k = 0; k < WIN; k++)
                    win_mark[k] = 1'b1;
        end
        lo = fin ? WIN - win_fill : 0;
        hi = fin ? WIN : (win_fill == WIN ? 1 : 0);
        for (int k = lo; k < hi; k++)
        begin
            w.mm = win_mark[k] ? INVALID_MM : win_mm[k];
            w.removed = win_mark[k];
            w.last = fin && (k == WIN - 1);
            expected_words = {expected_words, w};
        end
        if (fin)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                win_mm[k] = '0;
                win_mark[k] = 1'b0;
            end
            win_fill = 0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_valid)
            begin
                predict_sample(range_mm, scan_end);
                accepted++;
            end
            if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_sample = pending_samples.pop_front();
                range_mm <= next_sample.mm;
                scan_end <= next_sample.last;
                sample_valid <= 1'b1;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d",
                             $realtime, range_out_mm, removed, scan_last);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("range_out_mm", want.mm, range_out_mm);
                    check_field("removed", want.removed, removed);
                    check_field("scan_last", want.last, scan_last);
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [APB_DATA_WIDTH-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_DISTANCE:     max_dist = val[CFG_WIDTH-1:0];
            REG_MIN_THRESH:       min_th = val[CFG_WIDTH-1:0];
            REG_COS_TWO_STEPS:    cos_q16 = val[CFG_WIDTH-1:0];
            REG_BREAKPOINT_RATIO: ratio_q16 = val[RATIO_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [APB_DATA_WIDTH-1:0] limit_mm,
                               logic [APB_DATA_WIDTH-1:0] thresh,
                               logic [APB_DATA_WIDTH-1:0] cosine,
                               logic [APB_DATA_WIDTH-1:0] ratio);
        write_reg(REG_MAX_DISTANCE, limit_mm);
        write_reg(REG_MIN_THRESH, thresh);
        write_reg(REG_COS_TWO_STEPS, cosine);
        write_reg(REG_BREAKPOINT_RATIO, ratio);
    endtask

    task automatic queue_sample(int mm, logic fin);
        sample_t s;
        s.mm = mm;
        s.last = fin;
        pending_samples = {pending_samples, s};
        queued++;
    endtask

    task automatic queue_scan(int scan[], int count);
        for (int i = 0; i < count; i++)
            queue_sample(scan[i], i == count - 1);
    endtask

    task automatic add_random_scans(int count);
        int target;
        int len;
        int v;
        int step;
        target = queued + count;
        while (queued < target)
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
            v = $urandom_range(1, 4000);
            step = ($urandom_range(1) == 1) ? $urandom_range(1, 40) : $urandom_range(50, 800);
            if ($urandom_range(1) == 1)
                step = -step;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) < 8)
                    v = v + step;
                else
                    case ($urandom_range(4))
                        0: v = 0;
                        1: v = INVALID_MM;
                        2: v = RMAX;
                        3: v = $urandom_range(RMAX);
                        default: ;
                    endcase
                if (v < 0)
                    v = 0;
                if (v > RMAX)
                    v = RMAX;
                queue_sample(v, i == len - 1);
            end
        end
    endtask

    task automatic drain();
        while (accepted != queued || expected_words.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        queue_scan('{0, RMAX, INVALID_MM}, 3);
        queue_scan('{5}, 1);
        queue_scan('{1000, 1100, 1200, 1300, 1400, 1500}, 6);
        queue_scan('{2000, 1900, 1800, 1700, 1600}, 5);
        queue_scan('{500, 600, 700, 600, 500}, 5);
        queue_scan('{99800, 99900, INVALID_MM, 100100, 100200}, 5);
        drain();

        load_config(RMAX, 0, 32'hFFFF_FFFF, RST_BREAKPOINT_RATIO);
        add_random_scans(15);
        drain();

        load_config(RST_MAX_DISTANCE, RST_MIN_THRESH, 0, 0);
        idle_pct = 67;
        add_random_scans(15);
        drain();

        load_config(32'hFFFF_FFFF, RMAX, COS_ONE, 32'hFFFF_FFFF);
        idle_pct = 0;
        stall_pct = 67;
        add_random_scans(15);
        drain();

        load_config($urandom_range(RMAX), $urandom_range(200),
                    $urandom_range(60000, 65536), $urandom_range(20000));
        idle_pct = 12;
        stall_pct = 12;
        add_random_scans(15);
        drain();

        load_config($urandom_range(2000, 5000), $urandom_range(50),
                    RST_COS_TWO_STEPS, $urandom_range(1000, 6000));
        idle_pct = 0;
        stall_pct = 0;
        add_random_scans(15);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
